// ----- src/ppe_pkg.sv -----
package ppe_pkg;

	// Default table depth
	localparam int MAX_POINTS_DEF = 64;

	// Payload widths
	localparam int XY_W  = 32;
	localparam int PAR_W = 40;
	localparam int ST_W  = 2;

	// Shared arithmetic unit widths and step counts
	localparam int ARG_W      = 72;
	localparam int DIV_W      = PAR_W + 1;
	localparam int STEP_W     = 7;
	localparam int MUL_STEPS  = DIV_W;
	localparam int DIV_STEPS  = ARG_W;
	localparam int SQRT_STEPS = ARG_W / 2;
	localparam logic [ARG_W-1:0] SQRT_ONE = {2'b01, {(ARG_W-2){1'b0}}};

	// Status codes
	localparam logic [ST_W-1:0] ST_OK   = 2'd0;
	localparam logic [ST_W-1:0] ST_FULL = 2'd1;
	localparam logic [ST_W-1:0] ST_FEW  = 2'd2;

	typedef enum logic [1:0] {
		FN_CLEAR,
		FN_APPEND,
		FN_POS,
		FN_PARAM
	} func_t;

	typedef enum logic [1:0] {
		AOP_MUL,
		AOP_DIV,
		AOP_SQRT
	} arith_op_t;

	typedef struct packed {
		logic      start;
		arith_op_t op;
	} arith_req_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_DECODE,
		S_A_RDA,
		S_A_RD0,
		S_A_RDC,
		S_A_D1,
		S_A_D2,
		S_D_MX,
		S_D_WX,
		S_D_MY,
		S_D_WY,
		S_D_SQ,
		S_D_WS,
		S_Q_CUM,
		S_Q_MOD,
		S_S_CHK,
		S_F_PI,
		S_F_PJ,
		S_F_GO,
		S_P_WX,
		S_P_DX,
		S_P_WY,
		S_P_DY,
		S_R_WX,
		S_R_WY,
		S_R_CHK,
		S_R_DV,
		S_R_TOT,
		S_R_MOD,
		S_RD_OUT,
		S_DONE
	} state_t;

	// Magnitude of a 33-bit signed difference
	function automatic logic [XY_W:0] mag33(input logic signed [XY_W:0] v);
		logic signed [XY_W:0] n;
		n = -v;
		return v[XY_W] ? n : v;
	endfunction

	// Saturating 40-bit add
	function automatic logic [PAR_W-1:0] sat40(input logic [PAR_W-1:0] a,
			input logic [PAR_W-1:0] b);
		logic [PAR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[PAR_W] ? {PAR_W{1'b1}} : s[PAR_W-1:0];
	endfunction

endpackage

// ----- src/ppe_chan_if.sv -----
interface ppe_cmd_if;
	import ppe_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [1:0]              func;
	logic signed [XY_W-1:0]  x_coord;
	logic signed [XY_W-1:0]  y_coord;
	logic [PAR_W-1:0]        param_in;

	modport source (output valid, func, x_coord, y_coord, param_in, input ready);
	modport sink   (input valid, func, x_coord, y_coord, param_in, output ready);
endinterface

interface ppe_rsp_if;
	import ppe_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [XY_W-1:0]  pos_x;
	logic signed [XY_W-1:0]  pos_y;
	logic [PAR_W-1:0]        param_out;
	logic [ST_W-1:0]         status;

	modport source (output valid, pos_x, pos_y, param_out, status, input ready);
	modport sink   (input valid, pos_x, pos_y, param_out, status, output ready);
endinterface

// ----- src/ppe_ram.sv -----
module ppe_ram #(
	parameter int W     = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [W-1:0]             wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [W-1:0]             rdata
);

	logic [W-1:0] mem [DEPTH];

	// One write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- src/ppe_arith.sv -----
module ppe_arith
	import ppe_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  arith_req_t       req,
	input  logic [ARG_W-1:0] opa,
	input  logic [DIV_W-1:0] opb,
	output logic             done,
	output logic [ARG_W-1:0] res,
	output logic [DIV_W-1:0] rem
);

	logic              busy_q;
	logic              done_q;
	arith_op_t         op_q;
	logic [STEP_W-1:0] cnt_q;
	logic [STEP_W-1:0] last;
	logic [ARG_W-1:0]  acc_q;
	logic [ARG_W-1:0]  sh_q;
	logic [ARG_W-1:0]  aux_q;
	logic [DIV_W-1:0]  r_q;

	logic [DIV_W:0]    trial;
	logic              div_ge;
	logic [ARG_W-1:0]  sq_sum;
	logic              sq_ge;

	// Last step index of the running operation
	always_comb begin
		case (op_q)
			AOP_MUL:  last = STEP_W'(MUL_STEPS - 1);
			AOP_DIV:  last = STEP_W'(DIV_STEPS - 1);
			AOP_SQRT: last = STEP_W'(SQRT_STEPS - 1);
			default:  last = '0;
		endcase
	end

	// Restoring divide and digit-by-digit root compares
	assign trial  = {r_q, sh_q[ARG_W-1]};
	assign div_ge = trial >= {1'b0, aux_q[DIV_W-1:0]};
	assign sq_sum = acc_q + aux_q;
	assign sq_ge  = sh_q >= sq_sum;

	// Step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			op_q   <= AOP_MUL;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q   <= req.op;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + STEP_W'(1);
				if (cnt_q == last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Shared shift datapath: one bit of product, quotient or root a cycle
	always_ff @(posedge clk) begin
		if (req.start) begin
			case (req.op)
				AOP_MUL: begin
					acc_q <= '0;
					sh_q  <= opa;
					aux_q <= ARG_W'(opb);
				end
				AOP_DIV: begin
					sh_q  <= opa;
					aux_q <= ARG_W'(opb);
					r_q   <= '0;
				end
				AOP_SQRT: begin
					sh_q  <= opa;
					acc_q <= '0;
					aux_q <= SQRT_ONE;
				end
				default: begin
					acc_q <= '0;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				AOP_MUL: begin
					if (aux_q[0]) begin
						acc_q <= acc_q + sh_q;
					end
					sh_q  <= {sh_q[ARG_W-2:0], 1'b0};
					aux_q <= {1'b0, aux_q[ARG_W-1:1]};
				end
				AOP_DIV: begin
					r_q  <= div_ge ? DIV_W'(trial - {1'b0, aux_q[DIV_W-1:0]})
					                : trial[DIV_W-1:0];
					sh_q <= {sh_q[ARG_W-2:0], div_ge};
				end
				AOP_SQRT: begin
					if (sq_ge) begin
						sh_q  <= sh_q - sq_sum;
						acc_q <= {1'b0, acc_q[ARG_W-1:1]} + aux_q;
					end else begin
						acc_q <= {1'b0, acc_q[ARG_W-1:1]};
					end
					aux_q <= {2'b00, aux_q[ARG_W-1:2]};
				end
				default: begin
					acc_q <= acc_q;
				end
			endcase
		end
	end

	assign done = done_q;
	assign res  = (op_q == AOP_DIV) ? sh_q : acc_q;
	assign rem  = r_q;

endmodule

// ----- src/polyline_path_param_engine.sv -----
// Closed-polyline path engine. Takes one command word at a time (clear, append waypoint,
// position from arc parameter, parameter from position) and returns exactly one result
// word for each. All arithmetic goes through one shared bit-serial unit (multiply,
// divide and square root); an append computes two distances, and a query may first
// wrap its parameter with a divide. Waypoints, segment lengths and cumulative lengths
// sit in RAMs with one write port and one registered read port, read one entry a cycle;
// the segment search walks them linearly. A new command is taken while the previous
// result word waits in the output register.
module polyline_path_param_engine
	import ppe_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cfg_we,
	input  logic     cfg_wdata,
	ppe_cmd_if.sink  cmd,
	ppe_rsp_if.source rsp
);

	localparam int AW = $clog2(MAX_POINTS);
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic [CW-1:0] ONE     = CW'(1);
	localparam logic [CW-1:0] TWO     = CW'(2);
	localparam logic [CW-1:0] THREE   = CW'(3);
	localparam logic [CW-1:0] CNT_MAX = CW'(MAX_POINTS);

	state_t state_q, state_d, ret_q;

	// Control state
	logic [CW-1:0]    cnt_q;
	logic [PAR_W-1:0] plen_q;
	logic             looped_q;
	logic             out_valid_q;

	// Latched command
	func_t                  func_q;
	logic signed [XY_W-1:0] cx_q, cy_q;
	logic [PAR_W-1:0]       par_q;

	// Working registers
	logic signed [XY_W-1:0] ax_q, ay_q, bx_q, by_q, p0x_q, p0y_q;
	logic [PAR_W-1:0]       base_q, len_q, off_q, dist_q;
	logic [AW-1:0]          idx_q;
	logic [2*XY_W+2:0]      sq_q;
	logic signed [68:0]     dot_q;
	logic [PAR_W+1:0]       tot_q;

	// Staged and output result
	logic signed [XY_W-1:0] rx_q, ry_q, ox_q, oy_q;
	logic [PAR_W-1:0]       rp_q, op_q;
	logic [ST_W-1:0]        st_q, ost_q;

	// Memory ports
	logic [AW-1:0]          rd_addr, wr_addr;
	logic                   pt_we, ln_we;
	logic [PAR_W-1:0]       seg_wd, cum_wd;
	logic signed [XY_W-1:0] px_rd, py_rd;
	logic [PAR_W-1:0]       seg_rd, cum_rd;

	// Arithmetic unit
	arith_req_t       areq;
	logic [ARG_W-1:0] a_opa, a_res;
	logic [DIV_W-1:0] a_opb, a_rem;
	logic             a_done;

	logic              in_rdy, load;
	logic [CW-1:0]     cm1, cm2, cm3, nxt;
	logic [AW-1:0]     j_idx;
	logic              found, wrap, past_end;
	logic signed [XY_W:0] dxa, dya, qxa, qya;
	logic [XY_W:0]     mdx, mdy, mqx, mqy;
	logic signed [68:0] prod_s;
	logic [PAR_W-1:0]  sat_cum;
	logic [PAR_W-1:0]  par_off;
	logic [XY_W-1:0]   qlo;

	assign cm1 = cnt_q - ONE;
	assign cm2 = cnt_q - TWO;
	assign cm3 = cnt_q - THREE;
	assign nxt = CW'(idx_q) + ONE;
	assign j_idx = (nxt == cnt_q) ? '0 : nxt[AW-1:0];
	assign found = (par_q <= cum_rd) || (CW'(idx_q) == cm1);
	assign past_end = !looped_q && (par_q >= cum_rd);
	assign wrap = (func_q == FN_POS) ? (looped_q && par_q >= plen_q)
	                                 : (looped_q && par_q > plen_q && plen_q != '0);

	// Segment and query vectors
	assign dxa = {bx_q[XY_W-1], bx_q} - {ax_q[XY_W-1], ax_q};
	assign dya = {by_q[XY_W-1], by_q} - {ay_q[XY_W-1], ay_q};
	assign qxa = {cx_q[XY_W-1], cx_q} - {ax_q[XY_W-1], ax_q};
	assign qya = {cy_q[XY_W-1], cy_q} - {ay_q[XY_W-1], ay_q};
	assign mdx = mag33(dxa);
	assign mdy = mag33(dya);
	assign mqx = mag33(qxa);
	assign mqy = mag33(qya);
	assign prod_s = $signed({1'b0, a_res[67:0]});
	assign sat_cum = sat40(base_q, dist_q);
	assign par_off = par_q - base_q;
	assign qlo = a_res[XY_W-1:0];
	assign load = (state_q == S_DONE) && (!out_valid_q || rsp.ready);

	// Next state, memory and arithmetic control
	always_comb begin
		state_d = state_q;
		in_rdy  = 1'b0;
		rd_addr = '0;
		wr_addr = cnt_q[AW-1:0];
		pt_we   = 1'b0;
		ln_we   = 1'b0;
		seg_wd  = '0;
		cum_wd  = '0;
		areq    = '{start: 1'b0, op: AOP_MUL};
		a_opa   = '0;
		a_opb   = '0;
		case (state_q)
			S_IDLE: begin
				in_rdy = 1'b1;
				if (cmd.valid) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				case (func_q)
					FN_CLEAR: state_d = S_DONE;
					FN_APPEND: begin
						if (cnt_q == CNT_MAX) begin
							state_d = S_DONE;
						end else begin
							pt_we   = 1'b1;
							ln_we   = 1'b1;
							rd_addr = cm1[AW-1:0];
							state_d = (cnt_q == '0) ? S_DONE : S_A_RDA;
						end
					end
					FN_POS: begin
						if (cnt_q == '0) begin
							state_d = S_DONE;
						end else if (cnt_q == ONE || par_q == '0 ||
								(looped_q && plen_q == '0)) begin
							rd_addr = '0;
							state_d = S_RD_OUT;
						end else begin
							rd_addr = cm2[AW-1:0];
							state_d = S_Q_CUM;
						end
					end
					FN_PARAM: begin
						if (cnt_q < TWO) begin
							state_d = S_DONE;
						end else begin
							rd_addr = cm2[AW-1:0];
							state_d = S_Q_CUM;
						end
					end
					default: state_d = S_DONE;
				endcase
			end
			S_A_RDA: begin
				rd_addr = '0;
				state_d = S_A_RD0;
			end
			S_A_RD0: begin
				rd_addr = cm3[AW-1:0];
				state_d = S_A_RDC;
			end
			S_A_RDC: state_d = S_D_MX;
			// distance subroutine: dx^2 + dy^2, then root
			S_D_MX: begin
				areq    = '{start: 1'b1, op: AOP_MUL};
				a_opa   = ARG_W'(mdx);
				a_opb   = DIV_W'(mdx);
				state_d = S_D_WX;
			end
			S_D_WX: if (a_done) state_d = S_D_MY;
			S_D_MY: begin
				areq    = '{start: 1'b1, op: AOP_MUL};
				a_opa   = ARG_W'(mdy);
				a_opb   = DIV_W'(mdy);
				state_d = S_D_WY;
			end
			S_D_WY: if (a_done) state_d = S_D_SQ;
			S_D_SQ: begin
				areq    = '{start: 1'b1, op: AOP_SQRT};
				a_opa   = ARG_W'(sq_q);
				state_d = S_D_WS;
			end
			S_D_WS: if (a_done) state_d = ret_q;
			S_A_D1: begin
				ln_we   = 1'b1;
				wr_addr = cm2[AW-1:0];
				seg_wd  = dist_q;
				cum_wd  = sat_cum;
				state_d = S_D_MX;
			end
			S_A_D2: begin
				ln_we   = 1'b1;
				wr_addr = cm1[AW-1:0];
				seg_wd  = dist_q;
				cum_wd  = sat_cum;
				state_d = S_DONE;
			end
			S_Q_CUM: begin
				if (past_end) begin
					if (func_q == FN_POS) begin
						rd_addr = cm1[AW-1:0];
						state_d = S_RD_OUT;
					end else begin
						state_d = S_DONE;
					end
				end else if (wrap) begin
					areq    = '{start: 1'b1, op: AOP_DIV};
					a_opa   = ARG_W'(par_q);
					a_opb   = DIV_W'(plen_q);
					state_d = S_Q_MOD;
				end else begin
					state_d = S_S_CHK;
				end
			end
			S_Q_MOD: if (a_done) state_d = S_S_CHK;
			// linear search, next entry read while this one is checked
			S_S_CHK: begin
				if (found) begin
					rd_addr = idx_q;
					state_d = S_F_PI;
				end else begin
					rd_addr = nxt[AW-1:0];
				end
			end
			S_F_PI: begin
				rd_addr = j_idx;
				state_d = S_F_PJ;
			end
			S_F_PJ: state_d = S_F_GO;
			S_F_GO: begin
				if (len_q == '0) begin
					state_d = S_DONE;
				end else if (func_q == FN_POS) begin
					areq    = '{start: 1'b1, op: AOP_MUL};
					a_opa   = ARG_W'(mdx);
					a_opb   = DIV_W'(off_q);
					state_d = S_P_WX;
				end else begin
					areq    = '{start: 1'b1, op: AOP_MUL};
					a_opa   = ARG_W'(mqx);
					a_opb   = DIV_W'(mdx);
					state_d = S_R_WX;
				end
			end
			// interpolation
			S_P_WX: begin
				if (a_done) begin
					areq    = '{start: 1'b1, op: AOP_DIV};
					a_opa   = a_res;
					a_opb   = DIV_W'(len_q);
					state_d = S_P_DX;
				end
			end
			S_P_DX: begin
				if (a_done) begin
					areq    = '{start: 1'b1, op: AOP_MUL};
					a_opa   = ARG_W'(mdy);
					a_opb   = DIV_W'(off_q);
					state_d = S_P_WY;
				end
			end
			S_P_WY: begin
				if (a_done) begin
					areq    = '{start: 1'b1, op: AOP_DIV};
					a_opa   = a_res;
					a_opb   = DIV_W'(len_q);
					state_d = S_P_DY;
				end
			end
			S_P_DY: if (a_done) state_d = S_DONE;
			// projection
			S_R_WX: begin
				if (a_done) begin
					areq    = '{start: 1'b1, op: AOP_MUL};
					a_opa   = ARG_W'(mqy);
					a_opb   = DIV_W'(mdy);
					state_d = S_R_WY;
				end
			end
			S_R_WY: if (a_done) state_d = S_R_CHK;
			S_R_CHK: begin
				if (dot_q[68] || dot_q == '0) begin
					state_d = S_DONE;
				end else begin
					areq    = '{start: 1'b1, op: AOP_DIV};
					a_opa   = ARG_W'($unsigned(dot_q));
					a_opb   = DIV_W'(len_q);
					state_d = S_R_DV;
				end
			end
			S_R_DV: if (a_done) state_d = S_R_TOT;
			S_R_TOT: begin
				if (tot_q > (PAR_W + 2)'(plen_q) && looped_q) begin
					areq    = '{start: 1'b1, op: AOP_DIV};
					a_opa   = ARG_W'(tot_q - (PAR_W + 2)'(1));
					a_opb   = DIV_W'(plen_q);
					state_d = S_R_MOD;
				end else begin
					state_d = S_DONE;
				end
			end
			S_R_MOD: if (a_done) state_d = S_DONE;
			S_RD_OUT: state_d = S_DONE;
			S_DONE: if (load) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Path control state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			plen_q      <= '0;
			looped_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				looped_q <= cfg_wdata;
			end
			if (state_q == S_DECODE) begin
				if (func_q == FN_CLEAR) begin
					cnt_q    <= '0;
					plen_q   <= '0;
					looped_q <= 1'b0;
				end else if (func_q == FN_APPEND && cnt_q != CNT_MAX) begin
					cnt_q <= cnt_q + ONE;
				end
			end
			if (state_q == S_A_D2) begin
				plen_q <= sat_cum;
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Working datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (cmd.valid) begin
					func_q <= func_t'(cmd.func);
					cx_q   <= cmd.x_coord;
					cy_q   <= cmd.y_coord;
					par_q  <= cmd.param_in;
					rx_q   <= '0;
					ry_q   <= '0;
					rp_q   <= '0;
					st_q   <= ST_OK;
				end
			end
			S_DECODE: begin
				idx_q  <= '0;
				base_q <= '0;
				case (func_q)
					FN_APPEND: begin
						if (cnt_q == CNT_MAX) begin
							st_q <= ST_FULL;
						end
						rp_q <= plen_q;
					end
					FN_POS: if (cnt_q == '0) st_q <= ST_FEW;
					FN_PARAM: if (cnt_q < TWO) st_q <= ST_FEW;
					default: st_q <= ST_OK;
				endcase
			end
			S_A_RDA: begin
				ax_q <= px_rd;
				ay_q <= py_rd;
				bx_q <= cx_q;
				by_q <= cy_q;
			end
			S_A_RD0: begin
				p0x_q <= px_rd;
				p0y_q <= py_rd;
			end
			S_A_RDC: begin
				base_q <= (cnt_q == TWO) ? '0 : cum_rd;
				ret_q  <= S_A_D1;
			end
			S_D_WX: if (a_done) sq_q <= a_res[2*XY_W+2:0];
			S_D_WY: if (a_done) sq_q <= sq_q + a_res[2*XY_W+2:0];
			S_D_WS: if (a_done) dist_q <= a_res[PAR_W-1:0];
			S_A_D1: begin
				base_q <= sat_cum;
				ax_q   <= cx_q;
				ay_q   <= cy_q;
				bx_q   <= p0x_q;
				by_q   <= p0y_q;
				ret_q  <= S_A_D2;
			end
			S_A_D2: rp_q <= sat_cum;
			S_Q_CUM: if (past_end && func_q == FN_PARAM) rp_q <= cum_rd;
			S_Q_MOD: if (a_done) par_q <= a_rem[PAR_W-1:0];
			S_S_CHK: begin
				if (!found) begin
					base_q <= cum_rd;
					idx_q  <= nxt[AW-1:0];
				end
			end
			S_F_PI: begin
				ax_q  <= px_rd;
				ay_q  <= py_rd;
				len_q <= seg_rd;
			end
			S_F_PJ: begin
				bx_q <= px_rd;
				by_q <= py_rd;
				if (par_q < base_q) begin
					off_q <= '0;
				end else if (par_off > len_q) begin
					off_q <= len_q;
				end else begin
					off_q <= par_off;
				end
			end
			S_F_GO: begin
				if (len_q == '0) begin
					if (func_q == FN_POS) begin
						rx_q <= ax_q;
						ry_q <= ay_q;
					end else begin
						rp_q <= base_q;
					end
				end
			end
			S_P_DX: if (a_done) rx_q <= dxa[XY_W] ? ax_q - qlo : ax_q + qlo;
			S_P_DY: if (a_done) ry_q <= dya[XY_W] ? ay_q - qlo : ay_q + qlo;
			S_R_WX: if (a_done) dot_q <= (qxa[XY_W] != dxa[XY_W]) ? -prod_s : prod_s;
			S_R_WY: begin
				if (a_done) begin
					dot_q <= dot_q + ((qya[XY_W] != dya[XY_W]) ? -prod_s : prod_s);
				end
			end
			S_R_CHK: if (dot_q[68] || dot_q == '0) rp_q <= base_q;
			S_R_DV: if (a_done) tot_q <= (PAR_W + 2)'(base_q) + a_res[PAR_W+1:0];
			S_R_TOT: begin
				if (tot_q > (PAR_W + 2)'(plen_q)) begin
					if (!looped_q) begin
						rp_q <= plen_q;
					end
				end else begin
					rp_q <= tot_q[PAR_W-1:0];
				end
			end
			S_R_MOD: if (a_done) rp_q <= a_rem[PAR_W-1:0] + PAR_W'(1);
			S_RD_OUT: begin
				rx_q <= px_rd;
				ry_q <= py_rd;
			end
			S_DONE: begin
				if (load) begin
					ox_q  <= rx_q;
					oy_q  <= ry_q;
					op_q  <= rp_q;
					ost_q <= st_q;
				end
			end
			default: idx_q <= idx_q;
		endcase
	end

	// Waypoint and length stores
	ppe_ram #(.W(XY_W), .DEPTH(MAX_POINTS)) u_px (
		.clk(clk), .we(pt_we), .waddr(wr_addr), .wdata(cx_q),
		.raddr(rd_addr), .rdata(px_rd)
	);
	ppe_ram #(.W(XY_W), .DEPTH(MAX_POINTS)) u_py (
		.clk(clk), .we(pt_we), .waddr(wr_addr), .wdata(cy_q),
		.raddr(rd_addr), .rdata(py_rd)
	);
	ppe_ram #(.W(PAR_W), .DEPTH(MAX_POINTS)) u_seg (
		.clk(clk), .we(ln_we), .waddr(wr_addr), .wdata(seg_wd),
		.raddr(rd_addr), .rdata(seg_rd)
	);
	ppe_ram #(.W(PAR_W), .DEPTH(MAX_POINTS)) u_cum (
		.clk(clk), .we(ln_we), .waddr(wr_addr), .wdata(cum_wd),
		.raddr(rd_addr), .rdata(cum_rd)
	);

	// Shared multiply, divide and root unit
	ppe_arith u_arith (
		.clk(clk), .arst_n(arst_n), .req(areq), .opa(a_opa), .opb(a_opb),
		.done(a_done), .res(a_res), .rem(a_rem)
	);

	assign cmd.ready     = in_rdy;
	assign rsp.valid     = out_valid_q;
	assign rsp.pos_x     = ox_q;
	assign rsp.pos_y     = oy_q;
	assign rsp.param_out = op_q;
	assign rsp.status    = ost_q;

endmodule

// ----- verif/polyline_path_param_engine_tb.sv -----
`timescale 1ns / 1ps

module polyline_path_param_engine_tb;
	import ppe_pkg::*;

	localparam int NPTS = MAX_POINTS_DEF;

	typedef struct packed {
		logic [XY_W-1:0]  px;
		logic [XY_W-1:0]  py;
		logic [PAR_W-1:0] pp;
		logic [ST_W-1:0]  st;
	} path_result_t;

	typedef struct packed {
		func_t            f;
		logic [XY_W-1:0]  x;
		logic [XY_W-1:0]  y;
		logic [PAR_W-1:0] p;
		bit               typed;
		path_result_t     res;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic cfg_wdata;

	ppe_cmd_if cmd_if ();
	ppe_rsp_if rsp_if ();

	polyline_path_param_engine u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.cmd      (cmd_if),
		.rsp      (rsp_if)
	);

	// Shadow copy of the path table
	logic signed [XY_W-1:0] wp_x [NPTS];
	logic signed [XY_W-1:0] wp_y [NPTS];
	logic [PAR_W-1:0]       seg_len [NPTS];
	logic [PAR_W-1:0]       cum_len [NPTS];
	int unsigned            n_pts;
	logic [PAR_W-1:0]       total_len;
	bit                     loop_mode;

	path_result_t pending_results[$];
	int unsigned  errs;
	bit           quiet;

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	initial begin
		#40ms;
		$display("polyline_path_param_engine regression: fail");
		$finish;
	end

	task automatic report(string what, logic [PAR_W-1:0] got, logic [PAR_W-1:0] exp);
		$display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp);
		errs++;
	endtask

	function automatic logic [33:0] abs34(logic signed [33:0] v);
		return v < 0 ? -v : v;
	endfunction

	function automatic logic [PAR_W-1:0] sat_sum(logic [PAR_W-1:0] a, logic [PAR_W-1:0] b);
		logic [PAR_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[PAR_W] ? {PAR_W{1'b1}} : s[PAR_W-1:0];
	endfunction

	// Floor of the euclidean distance, bit by bit root
	function automatic logic [PAR_W-1:0] seg_dist(logic signed [XY_W-1:0] x0,
			logic signed [XY_W-1:0] y0, logic signed [XY_W-1:0] x1,
			logic signed [XY_W-1:0] y1);
		logic [71:0] ux, uy, sq, r, c;
		ux = 72'(abs34(34'(x1) - 34'(x0)));
		uy = 72'(abs34(34'(y1) - 34'(y0)));
		sq = ux * ux + uy * uy;
		r = '0;
		for (int b = 34; b >= 0; b--) begin
			c = r | (72'd1 << b);
			if (c * c <= sq)
				r = c;
		end
		return r[PAR_W-1:0];
	endfunction

	function automatic int unsigned seg_of(logic [PAR_W-1:0] p);
		for (int unsigned i = 0; i < n_pts; i++)
			if (p <= cum_len[i])
				return i;
		return n_pts - 1;
	endfunction

	function automatic logic [PAR_W-1:0] seg_base(int unsigned i);
		return i == 0 ? '0 : cum_len[i-1];
	endfunction

	// Path engine behaviour: updates the shadow table, returns the result word
	function automatic path_result_t path_predict(func_t f, logic signed [XY_W-1:0] cx,
			logic signed [XY_W-1:0] cy, logic [PAR_W-1:0] par);
		path_result_t r;
		int unsigned a, b, i, j;
		logic [PAR_W-1:0] len, off, base;
		logic signed [33:0] dx, dy, ax, ay;
		logic [79:0] q, tot, udot;
		logic signed [79:0] dot;
		longint sx, sy;
		r = '0;
		r.st = ST_OK;
		case (f)
			FN_CLEAR: begin
				n_pts = 0;
				total_len = '0;
				loop_mode = 1'b0;
			end
			FN_APPEND: begin
				if (n_pts >= NPTS) begin
					r.st = ST_FULL;
				end else begin
					wp_x[n_pts] = cx;
					wp_y[n_pts] = cy;
					seg_len[n_pts] = '0;
					cum_len[n_pts] = '0;
					n_pts++;
					if (n_pts >= 2) begin
						a = n_pts - 2;
						b = n_pts - 1;
						seg_len[a] = seg_dist(wp_x[a], wp_y[a], cx, cy);
						seg_len[b] = seg_dist(cx, cy, wp_x[0], wp_y[0]);
						cum_len[a] = sat_sum(seg_base(a), seg_len[a]);
						cum_len[b] = sat_sum(cum_len[a], seg_len[b]);
						total_len = cum_len[b];
					end
				end
				r.pp = total_len;
			end
			FN_POS: begin
				if (n_pts == 0) begin
					r.st = ST_FEW;
				end else if (n_pts == 1 || par == 0 || (loop_mode && total_len == 0)) begin
					r.px = wp_x[0];
					r.py = wp_y[0];
				end else if (!loop_mode && par >= cum_len[n_pts-2]) begin
					r.px = wp_x[n_pts-1];
					r.py = wp_y[n_pts-1];
				end else begin
					if (loop_mode && par >= total_len)
						par = par % total_len;
					i = seg_of(par);
					j = (i + 1 == n_pts) ? 0 : i + 1;
					len = seg_len[i];
					sx = wp_x[i];
					sy = wp_y[i];
					if (len != 0) begin
						base = seg_base(i);
						off = par >= base ? par - base : '0;
						if (off > len)
							off = len;
						dx = 34'(wp_x[j]) - 34'(wp_x[i]);
						dy = 34'(wp_y[j]) - 34'(wp_y[i]);
						q = (80'(abs34(dx)) * 80'(off)) / 80'(len);
						sx = dx < 0 ? sx - longint'(q[63:0]) : sx + longint'(q[63:0]);
						q = (80'(abs34(dy)) * 80'(off)) / 80'(len);
						sy = dy < 0 ? sy - longint'(q[63:0]) : sy + longint'(q[63:0]);
					end
					r.px = sx[XY_W-1:0];
					r.py = sy[XY_W-1:0];
				end
			end
			default: begin
				if (n_pts < 2) begin
					r.st = ST_FEW;
				end else if (!loop_mode && par >= cum_len[n_pts-2]) begin
					r.pp = cum_len[n_pts-2];
				end else begin
					if (loop_mode && par > total_len && total_len != 0)
						par = par % total_len;
					i = seg_of(par);
					j = (i + 1 == n_pts) ? 0 : i + 1;
					len = seg_len[i];
					base = seg_base(i);
					r.pp = base;
					if (len != 0) begin
						ax = 34'(cx) - 34'(wp_x[i]);
						ay = 34'(cy) - 34'(wp_y[i]);
						dx = 34'(wp_x[j]) - 34'(wp_x[i]);
						dy = 34'(wp_y[j]) - 34'(wp_y[i]);
						dot = 80'(ax) * 80'(dx) + 80'(ay) * 80'(dy);
						// projection behind the segment start keeps the base
						if (dot >= 0) begin
							udot = dot;
							tot = 80'(base) + udot / 80'(len);
							if (tot > 80'(total_len))
								tot = loop_mode ? ((tot - 1) % 80'(total_len)) + 1 :
									80'(total_len);
							r.pp = tot[PAR_W-1:0];
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	// Send one command word, predict it at acceptance
	task automatic push_cmd(func_t f, logic [XY_W-1:0] x, logic [XY_W-1:0] y,
			logic [PAR_W-1:0] p, bit typed = 0, path_result_t exp = '0);
		path_result_t r;
		while (!quiet && $urandom_range(99) < 12) begin
			cmd_if.valid <= 1'b0;
			@(posedge clk);
		end
		cmd_if.valid    <= 1'b1;
		cmd_if.func     <= f;
		cmd_if.x_coord  <= x;
		cmd_if.y_coord  <= y;
		cmd_if.param_in <= p;
		do
			@(posedge clk);
		while (!cmd_if.ready);
		r = path_predict(f, x, y, p);
		pending_results.push_back(typed ? exp : r);
	endtask

	// Register write once the block has drained
	task automatic write_loop(bit v);
		cmd_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we    <= 1'b0;
		loop_mode = v;
	endtask

	function automatic logic [XY_W-1:0] rand_coord(bit wide);
		return wide ? XY_W'($urandom) : XY_W'(int'($urandom_range(2 << 20)) - (1 << 20));
	endfunction

	function automatic logic [PAR_W-1:0] rand_param();
		logic [PAR_W-1:0] p;
		case ($urandom_range(9))
			0: p = '0;
			1: p = {$urandom, $urandom};
			2: p = total_len;
			3: p = n_pts > 1 ? cum_len[$urandom_range(n_pts - 1)] : '0;
			default: p = 41'(total_len) * $urandom_range(1200) / 1000;
		endcase
		return p;
	endfunction

	// Result side: random stall, compare against the oldest expectation
	always @(posedge clk) begin
		path_result_t e;
		if (!arst_n) begin
			rsp_if.ready <= 1'b0;
		end else begin
			rsp_if.ready <= quiet || $urandom_range(99) >= 12;
			if (rsp_if.valid && rsp_if.ready) begin
				if (pending_results.size() == 0) begin
					report("unexpected word", rsp_if.param_out, '0);
				end else begin
					e = pending_results.pop_front();
					if (rsp_if.pos_x !== e.px)
						report("pos_x", rsp_if.pos_x, e.px);
					if (rsp_if.pos_y !== e.py)
						report("pos_y", rsp_if.pos_y, e.py);
					if (rsp_if.param_out !== e.pp)
						report("param_out", rsp_if.param_out, e.pp);
					if (rsp_if.status !== e.st)
						report("status", rsp_if.status, e.st);
				end
			end
		end
	end

	// Directed rows, open path after reset
	dir_row_t dir_tab [17] = '{
		'{FN_POS,    32'h0, 32'h0, 40'h0, 1'b1, '{32'h0, 32'h0, 40'h0, ST_FEW}},
		'{FN_PARAM,  32'h0, 32'h0, 40'h5, 1'b1, '{32'h0, 32'h0, 40'h0, ST_FEW}},
		'{FN_APPEND, 32'h0, 32'h0, 40'h0, 1'b1, '{32'h0, 32'h0, 40'h0, ST_OK}},
		'{FN_PARAM,  32'h1234, 32'hffff0000, 40'h99, 1'b1,
			'{32'h0, 32'h0, 40'h0, ST_FEW}},
		'{FN_POS,    32'h0, 32'h0, 40'h1234, 1'b1, '{32'h0, 32'h0, 40'h0, ST_OK}},
		'{FN_APPEND, 32'h30000, 32'h40000, 40'h0, 1'b1,
			'{32'h0, 32'h0, 40'ha0000, ST_OK}},
		'{FN_POS,    32'h0, 32'h0, 40'h28000, 1'b0, '0},
		'{FN_APPEND, 32'h7fffffff, 32'h80000000, 40'h0, 1'b0, '0},
		'{FN_APPEND, 32'h7fffffff, 32'h80000000, 40'h0, 1'b0, '0},
		'{FN_POS,    32'h0, 32'h0, 40'h0, 1'b1, '{32'h0, 32'h0, 40'h0, ST_OK}},
		'{FN_POS,    32'h0, 32'h0, 40'hffffffffff, 1'b1,
			'{32'h7fffffff, 32'h80000000, 40'h0, ST_OK}},
		'{FN_POS,    32'h0, 32'h0, 40'h50000, 1'b0, '0},
		'{FN_PARAM,  32'h80000000, 32'h7fffffff, 40'h0, 1'b0, '0},
		'{FN_PARAM,  32'h7fffffff, 32'h80000000, 40'hffffffffff, 1'b0, '0},
		'{FN_PARAM,  32'h18000, 32'h20000, 40'h10000, 1'b0, '0},
		'{FN_POS,    32'h0, 32'h0, 40'h6000000000, 1'b0, '0},
		'{FN_CLEAR,  32'hffffffff, 32'hffffffff, 40'hffffffffff, 1'b1, '0}
	};

	initial begin
		int unsigned sent, pts, phase;
		bit wide;
		errs = 0;
		quiet = 0;
		n_pts = 0;
		total_len = '0;
		loop_mode = 1'b0;
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= 1'b0;
		cmd_if.valid <= 1'b0;
		cmd_if.func <= FN_CLEAR;
		cmd_if.x_coord <= '0;
		cmd_if.y_coord <= '0;
		cmd_if.param_in <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[k])
			push_cmd(dir_tab[k].f, dir_tab[k].x, dir_tab[k].y, dir_tab[k].p,
				dir_tab[k].typed, dir_tab[k].res);
		sent = $size(dir_tab);

		// Random paths: clear, set mode, build, then query with some noise
		phase = 0;
		while (sent < 1250) begin
			quiet = phase >= 6 && phase < 10;
			push_cmd(FN_CLEAR, XY_W'($urandom), XY_W'($urandom), {$urandom, $urandom});
			write_loop(phase % 2 == 1 || $urandom_range(3) == 0);
			wide = $urandom_range(3) == 0;
			pts = phase == 3 || phase == 20 ? NPTS + 2 :
				($urandom_range(9) == 0 ? 1 : $urandom_range(2, 8));
			for (int k = 0; k < pts; k++) begin
				if (k > 0 && $urandom_range(7) == 0)
					push_cmd(FN_APPEND, wp_x[n_pts-1], wp_y[n_pts-1], {$urandom, $urandom});
				else
					push_cmd(FN_APPEND, rand_coord(wide), rand_coord(wide),
						{$urandom, $urandom});
			end
			sent += pts + 1;
			repeat ($urandom_range(10, 25)) begin
				if ($urandom_range(19) == 0)
					push_cmd(func_t'($urandom_range(3)), rand_coord(1), rand_coord(1),
						{$urandom, $urandom});
				else
					push_cmd($urandom_range(1) ? FN_POS : FN_PARAM, rand_coord(wide),
						rand_coord(wide), rand_param());
				sent++;
			end
			phase++;
		end
		write_loop(1'b0);

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (500) @(posedge clk);
		if (errs == 0)
			$display("polyline_path_param_engine regression: pass");
		else
			$display("polyline_path_param_engine regression: fail");
		$finish;
	end

endmodule
